// ===== src/delta_sleep_queue_defines.svh =====
// assertion macros for the delta sleep queue
// expects clk and rst in the scope of the user
`ifndef DELTA_SLEEP_QUEUE_DEFINES_SVH
`define DELTA_SLEEP_QUEUE_DEFINES_SVH

// condition holds at every edge out of reset
`define DSQ_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DSQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define DSQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dsq_pkg.sv =====
// shared types and codes of the delta sleep queue
// used by the top level and the arithmetic unit
package dsq_pkg;

  localparam int ID_W    = 8;
  localparam int SLEEP_W = 32;
  localparam int KIND_W  = 2;

  localparam logic OP_SLEEP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_WAKE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLEEP,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_TICK_RD,
    ST_TICK_DEC,
    ST_WAKE_RD,
    ST_WAKE_CHK,
    ST_WAKE_LAST
  } state_t;

endpackage

// ===== src/dsq_ram.sv =====
// generic single write port, single read port memory with registered read
// no dependencies
module dsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dsq_alu.sv =====
// shared adder/subtractor with a compare against a limit
// depends on dsq_pkg for the operation codes
module dsq_alu import dsq_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  alu_op_t          op,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] c,
  output logic [WIDTH:0]   res,
  output logic             le
);

  always_comb begin
    case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
      default: res = '0;
    endcase
    // carry bit kept so a sum past the field width never looks small
    le = (res <= {1'b0, c});
  end

endmodule

// ===== src/delta_sleep_queue.sv =====
// delta sleep queue: sequencer, entry memory and shared arithmetic unit
// depends on dsq_pkg, dsq_ram, dsq_alu and delta_sleep_queue_defines.svh
//
// A beat is taken when start is high and busy is low; busy stays high until
// the item is finished. Results come at most one per cycle on kind, woken_id
// and last, each marked by strobe for a single cycle, and must be taken as
// they come. Entries live in a circular buffer in one memory with a single
// registered read port, and that port sets the pace: a sleep walks to the
// insert point, then moves the tail up by one, and is dropped when the queue
// is full. A tick decrements the head delta, held at zero, and wakes each
// thread at the head whose delta is zero; on an empty queue it gives no
// result. Each result shows in the cycle after the state that produces it,
// so the last one is on the ports in the first cycle with busy low.
`include "delta_sleep_queue_defines.svh"

module delta_sleep_queue import dsq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TICK_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [ID_W-1:0]   thread_id,
  input  logic [SLEEP_W-1:0] sleep_ticks,
  output logic              strobe,
  output logic [KIND_W-1:0] kind,
  output logic [ID_W-1:0]   woken_id,
  output logic              last
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TB = TICK_BITS;
  localparam int SW = (TICK_BITS > SLEEP_W) ? TICK_BITS : SLEEP_W;
  localparam int MW = ID_W + TB;
  localparam logic [SW-1:0] DMAX = SW'({TICK_BITS{1'b1}});
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  // logical list position to memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(hd) + (CW+1)'(l);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] idx, idx_next;
  logic [TB-1:0] sum, sum_next;
  logic [TB-1:0] ticks, ticks_next;
  logic [TB-1:0] rel, rel_next;
  logic [ID_W-1:0] tid, tid_next;
  logic [ID_W-1:0] pend_id, pend_id_next;
  logic strobe_next;
  logic [KIND_W-1:0] kind_next;
  logic [ID_W-1:0] woken_id_next;
  logic last_next;

  logic [SW-1:0] ticks_ext;
  logic [TB-1:0] ticks_sat;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;
  logic [ID_W-1:0] rd_id;
  logic [TB-1:0]   rd_delta;

  alu_op_t       alu_op;
  logic [TB-1:0] alu_a, alu_b, alu_c;
  logic [TB:0]   alu_res;
  logic          alu_le;
  logic [TB-1:0] dec;

  dsq_ram #(
    .WIDTH (MW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dsq_alu #(
    .WIDTH (TB)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .res (alu_res),
    .le  (alu_le)
  );

  assign rd_id    = mem_rdata[MW-1:TB];
  assign rd_delta = mem_rdata[TB-1:0];
  assign busy     = (state != ST_IDLE);

  // sleep length clamped to what a delta can hold
  assign ticks_ext = SW'(sleep_ticks);
  assign ticks_sat = (ticks_ext > DMAX) ? TB'(DMAX) : TB'(ticks_ext);

  // head delta after a tick, held at zero
  assign dec = (rd_delta == '0) ? '0 : alu_res[TB-1:0];

  always_comb begin
    state_next    = state;
    count_next    = count;
    head_next     = head;
    pos_next      = pos;
    idx_next      = idx;
    sum_next      = sum;
    ticks_next    = ticks;
    rel_next      = rel;
    tid_next      = tid;
    pend_id_next  = pend_id;
    strobe_next   = 1'b0;
    kind_next     = kind;
    woken_id_next = woken_id;
    last_next     = last;
    mem_we        = 1'b0;
    mem_waddr     = head;
    mem_wdata     = {rd_id, rd_delta};
    mem_raddr     = head;
    alu_op        = ALU_SUB;
    alu_a         = rd_delta;
    alu_b         = TB'(1);
    alu_c         = ticks;

    case (state)
      ST_IDLE: begin
        if (start) begin
          tid_next   = thread_id;
          ticks_next = ticks_sat;
          state_next = (opcode == OP_SLEEP) ? ST_SLEEP : ST_TICK_RD;
        end
      end

      ST_SLEEP: begin
        if (count == FULL) begin
          strobe_next   = 1'b1;
          kind_next     = KIND_DROP;
          woken_id_next = tid;
          last_next     = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          pos_next   = '0;
          sum_next   = '0;
          state_next = ST_WALK_RD;
        end
      end

      ST_WALK_RD: begin
        mem_raddr = phys(head, pos);
        if (pos == count) begin
          idx_next   = count;
          state_next = ST_SHIFT_RD;
        end else begin
          state_next = ST_WALK_CMP;
        end
      end

      ST_WALK_CMP: begin
        alu_op = ALU_ADD;
        alu_a  = sum;
        alu_b  = rd_delta;
        alu_c  = ticks;
        if (alu_le) begin
          sum_next   = alu_res[TB-1:0];
          pos_next   = pos + ONE;
          state_next = ST_WALK_RD;
        end else begin
          idx_next   = count;
          state_next = ST_SHIFT_RD;
        end
      end

      ST_SHIFT_RD: begin
        alu_a     = ticks;
        alu_b     = sum;
        rel_next  = alu_res[TB-1:0];
        mem_raddr = phys(head, idx - ONE);
        state_next = (idx == pos) ? ST_INSERT : ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        // the successor of the new entry gives up the new entry's delay
        alu_a     = rd_delta;
        alu_b     = rel;
        mem_we    = 1'b1;
        mem_waddr = phys(head, idx);
        if ((idx - ONE) == pos) begin
          mem_wdata = {rd_id, alu_res[TB-1:0]};
        end else begin
          mem_wdata = {rd_id, rd_delta};
        end
        idx_next   = idx - ONE;
        state_next = ST_SHIFT_RD;
      end

      ST_INSERT: begin
        mem_we        = 1'b1;
        mem_waddr     = phys(head, pos);
        mem_wdata     = {tid, rel};
        count_next    = count + ONE;
        strobe_next   = 1'b1;
        kind_next     = KIND_ACCEPT;
        woken_id_next = tid;
        last_next     = 1'b1;
        state_next    = ST_IDLE;
      end

      ST_TICK_RD: begin
        state_next = (count == '0) ? ST_IDLE : ST_TICK_DEC;
      end

      ST_TICK_DEC: begin
        if (dec != '0) begin
          mem_we     = 1'b1;
          mem_wdata  = {rd_id, dec};
          state_next = ST_IDLE;
        end else begin
          head_next  = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
          count_next = count - ONE;
          if (count == ONE) begin
            strobe_next   = 1'b1;
            kind_next     = KIND_WAKE;
            woken_id_next = rd_id;
            last_next     = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            pend_id_next = rd_id;
            state_next   = ST_WAKE_RD;
          end
        end
      end

      ST_WAKE_RD: begin
        state_next = ST_WAKE_CHK;
      end

      ST_WAKE_CHK: begin
        // the held thread is last unless the new head wakes too
        strobe_next   = 1'b1;
        kind_next     = KIND_WAKE;
        woken_id_next = pend_id;
        if (rd_delta == '0) begin
          last_next    = 1'b0;
          pend_id_next = rd_id;
          head_next    = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
          count_next   = count - ONE;
          state_next   = (count == ONE) ? ST_WAKE_LAST : ST_WAKE_RD;
        end else begin
          last_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_WAKE_LAST: begin
        strobe_next   = 1'b1;
        kind_next     = KIND_WAKE;
        woken_id_next = pend_id;
        last_next     = 1'b1;
        state_next    = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      head   <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      head   <= head_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    idx      <= idx_next;
    sum      <= sum_next;
    ticks    <= ticks_next;
    rel      <= rel_next;
    tid      <= tid_next;
    pend_id  <= pend_id_next;
    kind     <= kind_next;
    woken_id <= woken_id_next;
    last     <= last_next;
  end

  `DSQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `DSQ_ASSERT_NOW(a_count_range, count <= FULL, "entry count past queue depth")
  `DSQ_ASSERT_IMP(a_drop_full, strobe && (kind == KIND_DROP), count == FULL, "drop while not full")
  `DSQ_ASSERT_NXT(a_last_ends, strobe && last, !strobe, "result right after a last result")

endmodule

// ===== dv/delta_sleep_queue_tb.sv =====
// self-checking testbench for the delta sleep queue: directed table, then random bursts
// depends on dsq_pkg and delta_sleep_queue; keeps its own copy of the delta list
`timescale 1ns / 1ps

module delta_sleep_queue_tb;
  import dsq_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int TICK_BITS      = 32;
  localparam int RANDOM_ITEMS   = 420;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int MAX_REPORTS    = 10;
  localparam logic [63:0] DELTA_MAX = {{(64-TICK_BITS){1'b0}}, {TICK_BITS{1'b1}}};

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   tid;
    logic [SLEEP_W-1:0] ticks;
    logic              typed;
    logic [KIND_W-1:0] kind;
  } stim_row_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              last;
  } outcome_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               opcode;
  logic [ID_W-1:0]    thread_id;
  logic [SLEEP_W-1:0] sleep_ticks;
  logic               strobe;
  logic [KIND_W-1:0]  kind;
  logic [ID_W-1:0]    woken_id;
  logic               last;

  // typed rows carry their own answer; the list copy is still advanced
  logic              row_typed;
  logic [KIND_W-1:0] row_kind;

  logic [ID_W-1:0]      dl_ids    [QUEUE_DEPTH];
  logic [TICK_BITS-1:0] dl_deltas [QUEUE_DEPTH];
  int                   dl_count = 0;
  outcome_t             outcomes_due[$];

  int mismatches  = 0;
  int idle_cycles = 0;

  stim_row_t directed_rows [25] = '{
    '{OP_TICK,  8'd0,   32'd0,          1'b0, KIND_WAKE},   // tick on empty queue
    '{OP_SLEEP, 8'd0,   32'd0,          1'b1, KIND_ACCEPT}, // zero sleep
    '{OP_TICK,  8'd0,   32'd0,          1'b0, KIND_WAKE},   // head delta zero, held at zero and woken
    '{OP_TICK,  8'd0,   32'd0,          1'b0, KIND_WAKE},
    '{OP_SLEEP, 8'd255, 32'hFFFF_FFFF,  1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd1,   32'd3,          1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd2,   32'd3,          1'b1, KIND_ACCEPT}, // equal delay goes behind
    '{OP_SLEEP, 8'd3,   32'd1,          1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd1,   32'd3,          1'b1, KIND_ACCEPT}, // same thread twice
    '{OP_SLEEP, 8'd10,  32'd0,          1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd11,  32'd2,          1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd12,  32'd5,          1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd13,  32'd7,          1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd14,  32'd100,        1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd15,  32'h8000_0000,  1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd16,  32'h7FFF_FFFF,  1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd17,  32'd1,          1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd18,  32'd4,          1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd19,  32'd9,          1'b1, KIND_ACCEPT},
    '{OP_SLEEP, 8'd20,  32'd0,          1'b1, KIND_ACCEPT}, // queue now full
    '{OP_SLEEP, 8'd21,  32'd2,          1'b1, KIND_DROP},
    '{OP_TICK,  8'd0,   32'd0,          1'b0, KIND_WAKE},
    '{OP_TICK,  8'd0,   32'd0,          1'b0, KIND_WAKE},
    '{OP_TICK,  8'd0,   32'd0,          1'b0, KIND_WAKE},
    '{OP_TICK,  8'd0,   32'd0,          1'b0, KIND_WAKE}
  };

  delta_sleep_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TICK_BITS  (TICK_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .thread_id  (thread_id),
    .sleep_ticks(sleep_ticks),
    .strobe     (strobe),
    .kind       (kind),
    .woken_id   (woken_id),
    .last       (last)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // apply one beat to the delta list copy and queue the results it causes
  function automatic void advance_delta_list(input logic op, input logic [ID_W-1:0] tid,
                                             input logic [SLEEP_W-1:0] ticks,
                                             input bit keep);
    logic [63:0] want;
    logic [63:0] sum;
    logic [63:0] step;
    logic [63:0] rel;
    int          pos;
    int          i;
    bit          have;
    outcome_t    o;
    if (op == OP_SLEEP) begin
      want = 64'(ticks);
      if (want > DELTA_MAX) want = DELTA_MAX;
      o.id   = tid;
      o.last = 1'b1;
      if (dl_count >= QUEUE_DEPTH) begin
        o.kind = KIND_DROP;
      end else begin
        sum = '0;
        pos = 0;
        step = (dl_count > 0) ? 64'(dl_deltas[0]) : '0;
        while (pos < dl_count && sum + step <= want) begin
          sum = sum + step;
          pos++;
          if (pos < dl_count) step = 64'(dl_deltas[pos]);
        end
        rel = want - sum;
        if (pos < dl_count) dl_deltas[pos] = dl_deltas[pos] - rel[TICK_BITS-1:0];
        for (i = dl_count; i > pos; i--) begin
          dl_ids[i]    = dl_ids[i-1];
          dl_deltas[i] = dl_deltas[i-1];
        end
        dl_ids[pos]    = tid;
        dl_deltas[pos] = rel[TICK_BITS-1:0];
        dl_count++;
        o.kind = KIND_ACCEPT;
      end
      if (keep) outcomes_due.push_back(o);
    end else if (dl_count > 0) begin
      if (dl_deltas[0] != '0) dl_deltas[0] = dl_deltas[0] - TICK_BITS'(1);
      have = 1'b0;
      while (dl_count > 0 && dl_deltas[0] == '0) begin
        if (have && keep) outcomes_due.push_back(o);
        o    = '{KIND_WAKE, dl_ids[0], 1'b0};
        have = 1'b1;
        for (i = 1; i < dl_count; i++) begin
          dl_ids[i-1]    = dl_ids[i];
          dl_deltas[i-1] = dl_deltas[i];
        end
        dl_count--;
      end
      if (have && keep) begin
        o.last = 1'b1;
        outcomes_due.push_back(o);
      end
    end
  endfunction

  function automatic logic [SLEEP_W-1:0] pick_sleep_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return SLEEP_W'($urandom_range(0, 12));
    if (r < 99) return SLEEP_W'($urandom_range(13, 60));
    return $urandom;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic drive_item(input logic op, input logic [ID_W-1:0] tid,
                            input logic [SLEEP_W-1:0] ticks);
    opcode      <= op;
    thread_id   <= tid;
    sleep_ticks <= ticks;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // results first: a result can end in the cycle the next beat is taken
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe || (start && !busy)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (strobe) begin
        if (outcomes_due.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: kind=%0d id=%0d last=%0d", kind, woken_id, last);
          mismatches <= mismatches + 1;
        end else begin
          if (kind !== outcomes_due[0].kind || woken_id !== outcomes_due[0].id ||
              last !== outcomes_due[0].last) begin
            if (mismatches < MAX_REPORTS)
              $display("mismatch: expected kind=%0d id=%0d last=%0d, got kind=%0d id=%0d last=%0d",
                       outcomes_due[0].kind, outcomes_due[0].id, outcomes_due[0].last,
                       kind, woken_id, last);
            mismatches <= mismatches + 1;
          end
          void'(outcomes_due.pop_front());
        end
      end
      if (start && !busy) begin
        advance_delta_list(opcode, thread_id, sleep_ticks, !row_typed);
        if (row_typed) outcomes_due.push_back('{row_kind, thread_id, 1'b1});
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("delta_sleep_queue_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int  sent;
    int  burst;
    int  k;
    int  sleep_pct;
    bit  paused;
    logic op;
    rst         = 1'b1;
    start       = 1'b0;
    opcode      = OP_SLEEP;
    thread_id   = '0;
    sleep_ticks = '0;
    row_typed   = 1'b0;
    row_kind    = KIND_WAKE;
    paused      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      row_typed = directed_rows[r].typed;
      row_kind  = directed_rows[r].kind;
      drive_item(directed_rows[r].op, directed_rows[r].tid, directed_rows[r].ticks);
    end
    row_typed = 1'b0;

    // alternate sleep-heavy and tick-heavy stretches so the queue fills and drains
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        while (outcomes_due.size() != 0 || busy) @(negedge clk);
      end
      burst = $urandom_range(1, 16);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        sleep_pct = ((sent / 40) % 2 == 0) ? 70 : 30;
        op = ($urandom_range(0, 99) < sleep_pct) ? OP_SLEEP : OP_TICK;
        drive_item(op, ID_W'($urandom_range(0, 255)), pick_sleep_ticks());
        sent++;
      end
    end
    start <= 1'b0;

    while (outcomes_due.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("delta_sleep_queue_tb: PASS");
    end else begin
      $display("delta_sleep_queue_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/dsq_pkg.sv
src/dsq_ram.sv
src/dsq_alu.sv
src/delta_sleep_queue.sv
dv/delta_sleep_queue_tb.sv
